### sv/stk_pkg.sv
// Shared types and constants of the spanning tree block.
package stk_pkg;

    localparam int VTX_BITS   = 5;
    localparam int SUM_BITS   = 21;
    localparam int VCNT_BITS  = 6;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
    localparam logic [VCNT_BITS-1:0] VCNT_RESET = 6'd32;

    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_FETCH,
        S_RDS,
        S_RDD,
        S_ERD,
        S_ETE,
        S_SUM
    } t_state;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_cell_ctl;

endpackage

### sv/stk_if.sv
// Edge request and result request channel interfaces.
interface stk_edge_if;
    import stk_pkg::*;
    logic                valid;
    logic                ready;
    logic [VTX_BITS-1:0] edge_src;
    logic [VTX_BITS-1:0] edge_dst;
    logic [15:0]         edge_weight;
    logic                edge_last;

    modport source (output valid, edge_src, edge_dst, edge_weight, edge_last, input ready);
    modport sink   (input valid, edge_src, edge_dst, edge_weight, edge_last, output ready);
endinterface

interface stk_res_if;
    import stk_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [VTX_BITS-1:0] tree_src;
    logic [VTX_BITS-1:0] tree_dst;
    logic [SUM_BITS-1:0] total_weight;
    logic                connected;
    logic                overflow;
    logic                last;

    modport source (output valid, kind, tree_src, tree_dst, total_weight, connected,
                    overflow, last, input ready);
    modport sink   (input valid, kind, tree_src, tree_dst, total_weight, connected,
                    overflow, last, output ready);
endinterface

### sv/stk_ram.sv
// Generic single-write, registered-read RAM.
module stk_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/stk_cell.sv
// One cell of the sorted edge chain: insert-shift toward the tail, pop toward the head.
module stk_cell
    import stk_pkg::*;
#(
    parameter int KW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [KW-1:0] i_new_key,
    input  logic [KW-1:0] i_prev_key,
    input  logic          i_prev_valid,
    input  logic          i_prev_lt,
    input  logic [KW-1:0] i_next_key,
    input  logic          i_next_valid,
    output logic [KW-1:0] o_key,
    output logic          o_valid,
    output logic          o_lt
);
    logic [KW-1:0] r_key;
    logic          r_valid;

    // empty cells act as +infinity so the chain stays sorted with holes at the tail
    assign o_lt = !r_valid || (i_new_key < r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_prev_lt) begin
                r_valid <= i_prev_valid;
            end else if (o_lt) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev_lt) begin
                r_key <= i_prev_key;
            end else if (o_lt) begin
                r_key <= i_new_key;
            end
        end else if (i_ctl.pop) begin
            r_key <= i_next_key;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;
endmodule

### sv/stk_forest.sv
// Row of vertex cells holding the component label of each vertex.
module stk_forest #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_init,
    input  logic                            i_join,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_from,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_to,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_raddr,
    output logic [$clog2(MAX_VERTICES)-1:0] o_rlabel
);
    localparam int VW = $clog2(MAX_VERTICES);

    logic [VW-1:0] r_label [MAX_VERTICES];

    for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_vtx
        always_ff @(posedge i_clk) begin
            if (i_init) begin
                r_label[v] <= VW'(v);
            end else if (i_join && r_label[v] == i_from) begin
                r_label[v] <= i_to;
            end
        end
    end

    assign o_rlabel = r_label[i_raddr];
endmodule

### sv/spanning_tree_kruskal.sv
// Kruskal spanning tree: insertion-sorting edge chain, label forest, result sequencer.
// Edges load one per cycle in the load state; each stored one lands sorted on arrival.
// After the last edge: a setup step, then for each stored edge scanned the steps pop,
// read source label, and read destination label and join; a final step ends the scan.
// Output: each tree edge is read from the tree buffer and sent, then the summary, plus stalls.
// Reset (synchronous, active low) empties the chain, clears counters, vertex_count = 32.
module spanning_tree_kruskal
    import stk_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 512,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stk_edge_if.sink    i_edge,
    stk_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int WB  = WEIGHT_BITS;
    localparam int KW  = WB + 2 * VTX_BITS;
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int CW  = $clog2(MAX_EDGES + 1);

    t_state r_state, n_state;

    logic [VCNT_BITS-1:0] r_vc;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_rem;
    logic                 r_ovf;
    logic [VW-1:0]        r_tec;
    logic [SUM_BITS-1:0]  r_sum;
    logic [KW-1:0]        r_e;
    logic [VW-1:0]        r_ls;
    logic [VW-1:0]        r_k;

    logic                 r_ov;
    logic                 r_kind;
    logic [VTX_BITS-1:0]  r_osrc;
    logic [VTX_BITS-1:0]  r_odst;
    logic [SUM_BITS-1:0]  r_otw;
    logic                 r_ocon;
    logic                 r_oovf;
    logic                 r_olast;

    // ---------------- configuration port ----------------
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, r_vc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= VCNT_RESET;
        end else if (cfg_we) begin
            r_vc <= pwdata[VCNT_BITS-1:0];
        end
    end

    logic [VCW-1:0] vc_e;
    always_comb begin
        if (r_vc == '0) begin
            vc_e = VCW'(1);
        end else if (32'(r_vc) > MAX_VERTICES) begin
            vc_e = VCW'(MAX_VERTICES);
        end else begin
            vc_e = VCW'(r_vc);
        end
    end

    // ---------------- edge chain ----------------
    logic [WB+15:0] w_ext;
    logic [KW-1:0]  new_key;
    logic           in_acc;
    logic           store_ok;
    t_cell_ctl      cell_ctl;

    assign w_ext    = {{WB{1'b0}}, i_edge.edge_weight};
    assign new_key  = {w_ext[WB-1:0], i_edge.edge_src, i_edge.edge_dst};
    assign i_edge.ready = (r_state == S_LOAD);
    assign in_acc   = i_edge.valid && i_edge.ready;
    assign store_ok = 32'(r_cnt) < MAX_EDGES;

    logic [KW-1:0] c_key   [MAX_EDGES];
    logic          c_valid [MAX_EDGES];
    logic          c_lt    [MAX_EDGES];

    for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
        logic [KW-1:0] prev_key, next_key;
        logic          prev_valid, prev_lt, next_valid;
        if (i == 0) begin : g_head
            assign prev_key   = '0;
            assign prev_valid = 1'b0;
            assign prev_lt    = 1'b0;
        end else begin : g_mid
            assign prev_key   = c_key[i-1];
            assign prev_valid = c_valid[i-1];
            assign prev_lt    = c_lt[i-1];
        end
        if (i == MAX_EDGES - 1) begin : g_tail
            assign next_key   = '0;
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_key   = c_key[i+1];
            assign next_valid = c_valid[i+1];
        end
        stk_cell #(.KW(KW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_new_key    (new_key),
            .i_prev_key   (prev_key),
            .i_prev_valid (prev_valid),
            .i_prev_lt    (prev_lt),
            .i_next_key   (next_key),
            .i_next_valid (next_valid),
            .o_key        (c_key[i]),
            .o_valid      (c_valid[i]),
            .o_lt         (c_lt[i])
        );
    end

    // ---------------- scan datapath ----------------
    logic [WB-1:0]       e_w;
    logic [VTX_BITS-1:0] e_s, e_d;
    assign e_w = r_e[KW-1:2*VTX_BITS];
    assign e_s = r_e[2*VTX_BITS-1:VTX_BITS];
    assign e_d = r_e[VTX_BITS-1:0];

    logic          f_init, f_join;
    logic [VW-1:0] f_raddr, f_rlabel;

    stk_forest #(.MAX_VERTICES(MAX_VERTICES)) u_forest (
        .i_clk    (i_clk),
        .i_init   (f_init),
        .i_join   (f_join),
        .i_from   (r_ls),
        .i_to     (f_rlabel),
        .i_raddr  (f_raddr),
        .o_rlabel (f_rlabel)
    );

    logic                  t_we;
    logic [2*VTX_BITS-1:0] t_rdata;

    stk_ram #(.WIDTH(2 * VTX_BITS), .DEPTH(MAX_VERTICES)) u_tree_buf (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_tec),
        .i_wdata ({e_s, e_d}),
        .i_raddr (r_k),
        .o_rdata (t_rdata)
    );

    logic more_tree, con, out_free, out_take, e_out_range;
    assign more_tree   = (32'(r_tec) + 1) < 32'(vc_e);
    assign con         = (32'(r_tec) + 1) == 32'(vc_e);
    assign out_take    = r_ov && o_res.ready;
    assign out_free    = !r_ov || o_res.ready;
    assign e_out_range = (32'(e_s) >= 32'(vc_e)) || (32'(e_d) >= 32'(vc_e));

    logic [32:0]         w33, room;
    logic [SUM_BITS-1:0] sum_next;
    assign w33  = 33'(e_w);
    assign room = 33'(SUM_MAX - r_sum);
    assign sum_next = (w33 >= room) ? SUM_MAX : SUM_BITS'(33'(r_sum) + w33);

    logic ld_edge, ld_sum;

    // ---------------- control ----------------
    always_comb begin
        n_state  = r_state;
        cell_ctl = '0;
        f_init   = 1'b0;
        f_join   = 1'b0;
        f_raddr  = VW'(e_s);
        t_we     = 1'b0;
        ld_edge  = 1'b0;
        ld_sum   = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    cell_ctl.ins = store_ok;
                    if (i_edge.edge_last) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                f_init  = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_rem == '0 || !more_tree) begin
                    n_state = S_ERD;
                end else begin
                    cell_ctl.pop = 1'b1;
                    n_state      = S_RDS;
                end
            end
            S_RDS: begin
                n_state = e_out_range ? S_FETCH : S_RDD;
            end
            S_RDD: begin
                f_raddr = VW'(e_d);
                if (r_ls != f_rlabel) begin
                    f_join = 1'b1;
                    t_we   = 1'b1;
                end
                n_state = S_FETCH;
            end
            S_ERD: begin
                n_state = (!con || r_k == r_tec) ? S_SUM : S_ETE;
            end
            S_ETE: begin
                if (out_free) begin
                    ld_edge = 1'b1;
                    n_state = S_ERD;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    ld_sum       = 1'b1;
                    cell_ctl.clr = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_tec <= '0;
            r_sum <= '0;
            r_k   <= '0;
            r_rem <= '0;
        end else begin
            if (in_acc) begin
                if (store_ok) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == S_PREP) begin
                r_tec <= '0;
                r_sum <= '0;
                r_k   <= '0;
                r_rem <= r_cnt;
            end
            if (cell_ctl.pop) begin
                r_rem <= r_rem - CW'(1);
            end
            if (t_we) begin
                r_tec <= r_tec + VW'(1);
                r_sum <= sum_next;
            end
            if (ld_edge) begin
                r_k <= r_k + VW'(1);
            end
            if (ld_sum) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctl.pop) begin
            r_e <= c_key[0];
        end
        if (r_state == S_RDS) begin
            r_ls <= f_rlabel;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld_edge || ld_sum) begin
            r_ov <= 1'b1;
        end else if (out_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_edge) begin
            r_kind  <= KIND_EDGE;
            r_osrc  <= t_rdata[2*VTX_BITS-1:VTX_BITS];
            r_odst  <= t_rdata[VTX_BITS-1:0];
            r_otw   <= '0;
            r_ocon  <= 1'b0;
            r_oovf  <= r_ovf;
            r_olast <= 1'b0;
        end else if (ld_sum) begin
            r_kind  <= KIND_SUMMARY;
            r_osrc  <= '0;
            r_odst  <= '0;
            r_otw   <= con ? r_sum : '0;
            r_ocon  <= con;
            r_oovf  <= r_ovf;
            r_olast <= 1'b1;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.kind         = r_kind;
    assign o_res.tree_src     = r_osrc;
    assign o_res.tree_dst     = r_odst;
    assign o_res.total_weight = r_otw;
    assign o_res.connected    = r_ocon;
    assign o_res.overflow     = r_oovf;
    assign o_res.last         = r_olast;

    // ---------------- assertions ----------------
    // the count still holds the previous run's value until setup clears it
    a_tec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tec) < 32'(vc_e) || r_state == S_LOAD || r_state == S_PREP)
        else $error("tree edge count passed vertex_count-1");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_valid[MAX_EDGES-1] |-> c_valid[0])
        else $error("edge chain has a hole at its head");

    a_rds_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RDS |-> $past(r_state) == S_FETCH)
        else $error("label read without a popped edge");

    a_no_result_while_scanning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDS || r_state == S_RDD) |-> !(ld_edge || ld_sum))
        else $error("result loaded during scan");
endmodule
